@@ rtl/core/ttuv_pkg.sv @@
package ttuv_pkg;

    // default widths, Q16.16
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // depth of the triangle queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // vertex layout: pos_x, pos_y, pos_z, tex_u, tex_v from the lowest field up
    localparam int VTX_FIELDS = 5;
    localparam int TRI_VERTS  = 3;
    localparam int FLD_POS    = 0;
    localparam int FLD_TEX_U  = 3;
    localparam int FLD_TEX_V  = 4;

    // delta layout inside a triangle record
    localparam int NUM_DELTAS = 10;
    localparam int DL_DU0     = 0;
    localparam int DL_DU1     = 1;
    localparam int DL_DV0     = 2;
    localparam int DL_DV1     = 3;
    localparam int DL_E0      = 4;
    localparam int DL_E1      = 7;

    // back-end sequencer
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_WAIT,
        BK_OUT
    } bk_state_t;

    // queue status
    typedef struct packed {
        logic full;
        logic empty;
    } ttuv_q_stat_t;

    // divider status
    typedef struct packed {
        logic busy;
        logic done;
    } ttuv_div_stat_t;

endpackage

@@ rtl/core/ttuv_fifo.sv @@
module ttuv_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [WIDTH-1:0]      wr_data,
    input  logic                  rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output ttuv_pkg::ttuv_q_stat_t stat
);
    import ttuv_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    // storage write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (rd_en) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            case ({wr_en, rd_en})
                2'b10:   count_reg <= count_reg + CW'(1);
                2'b01:   count_reg <= count_reg - CW'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    assign rd_data    = rd_data_reg;
    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

@@ rtl/core/ttuv_div.sv @@
module ttuv_div #(
    parameter int DATA_WIDTH = ttuv_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = ttuv_pkg::FRAC_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic [2*DATA_WIDTH+1+FRAC_BITS-1:0]    num,
    input  logic [2*DATA_WIDTH+1-1:0]              den,
    input  logic                                   neg,
    output ttuv_pkg::ttuv_div_stat_t               stat,
    output logic [DATA_WIDTH-1:0]                  res
);
    import ttuv_pkg::*;

    localparam int W    = DATA_WIDTH;
    localparam int MW   = 2 * W + 1;
    localparam int NW   = MW + FRAC_BITS;
    localparam int HW   = NW - W;
    localparam int CW   = (HW > MW) ? HW : MW;
    localparam int CNTW = $clog2(W + 1);

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [MW:0]     rem_reg;
    logic [W-1:0]    q_reg;
    logic [MW-1:0]   den_reg;
    logic            neg_reg;
    logic            ovf_reg;
    logic [W-1:0]    res_reg;

    logic [CW:0]     hi_ext;
    logic [CW:0]     den_ext;
    logic            ovf_in;
    logic [MW:0]     sh;
    logic [MW:0]     diff;
    logic            ge;
    logic [W-1:0]    lim;
    logic [W-1:0]    mag;
    logic [W-1:0]    res_next;
    logic            finish;

    // quotient of 2^W or more saturates without iterating
    assign hi_ext  = (CW + 1)'(num[NW-1:W]);
    assign den_ext = (CW + 1)'(den);
    assign ovf_in  = (hi_ext >= den_ext);

    // one restoring step per cycle
    assign sh   = {rem_reg[MW-1:0], q_reg[W-1]};
    assign diff = sh - {1'b0, den_reg};
    assign ge   = (sh >= {1'b0, den_reg});

    // saturate and apply sign
    assign lim      = neg_reg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    assign mag      = (ovf_reg || (q_reg > lim)) ? lim : q_reg;
    assign res_next = neg_reg ? (W'(0) - mag) : mag;
    assign finish   = (cnt_reg == '0) || ovf_reg;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && finish) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= (MW + 1)'(num[NW-1:W]);
            q_reg   <= num[W-1:0];
            den_reg <= den;
            neg_reg <= neg;
            ovf_reg <= ovf_in;
            cnt_reg <= CNTW'(W);
        end else if (busy_reg) begin
            if (finish) begin
                res_reg <= res_next;
            end else begin
                rem_reg <= ge ? diff : sh;
                q_reg   <= {q_reg[W-2:0], ge};
                cnt_reg <= cnt_reg - CNTW'(1);
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign res       = res_reg;

endmodule

@@ rtl/core/ttuv_front.sv @@
module ttuv_front #(
    parameter int DATA_WIDTH = ttuv_pkg::DATA_WIDTH_DEF,
    parameter int REC_WIDTH  = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [5*DATA_WIDTH-1:0]       vtx_in,
    input  ttuv_pkg::ttuv_q_stat_t        q_stat,
    output logic                          q_wr,
    output logic [REC_WIDTH-1:0]          q_data
);
    import ttuv_pkg::*;

    localparam int W   = DATA_WIDTH;
    localparam int VW  = VTX_FIELDS * W;
    localparam int DLW = W + 1;

    logic [1:0]                  slot_reg;
    logic [VW-1:0]               v0_reg;
    logic [VW-1:0]               v1_reg;
    logic                        accept;
    logic                        third;
    logic [NUM_DELTAS*DLW-1:0]   dl_flat;

    function automatic logic [DLW-1:0] dif(input logic [W-1:0] a, input logic [W-1:0] b);
        dif = {a[W-1], a} - {b[W-1], b};
    endfunction

    // slot two or more completes a triangle
    assign third    = slot_reg[1];
    assign s_tready = !third || !q_stat.full;
    assign accept   = s_tvalid && s_tready;
    assign q_wr     = accept && third;

    // uv deltas and edge vectors, exact in one extra bit
    always_comb begin
        dl_flat = '0;
        dl_flat[DL_DU0*DLW +: DLW] = dif(v1_reg[FLD_TEX_U*W +: W], v0_reg[FLD_TEX_U*W +: W]);
        dl_flat[DL_DU1*DLW +: DLW] = dif(vtx_in[FLD_TEX_U*W +: W], v0_reg[FLD_TEX_U*W +: W]);
        dl_flat[DL_DV0*DLW +: DLW] = dif(v1_reg[FLD_TEX_V*W +: W], v0_reg[FLD_TEX_V*W +: W]);
        dl_flat[DL_DV1*DLW +: DLW] = dif(vtx_in[FLD_TEX_V*W +: W], v0_reg[FLD_TEX_V*W +: W]);
        for (int c = 0; c < 3; c++) begin
            dl_flat[(DL_E0+c)*DLW +: DLW] =
                dif(v1_reg[(FLD_POS+c)*W +: W], v0_reg[(FLD_POS+c)*W +: W]);
            dl_flat[(DL_E1+c)*DLW +: DLW] =
                dif(vtx_in[(FLD_POS+c)*W +: W], v0_reg[(FLD_POS+c)*W +: W]);
        end
    end

    assign q_data = REC_WIDTH'({dl_flat, vtx_in, v1_reg, v0_reg});

    // held vertices
    always_ff @(posedge aclk) begin
        if (accept && (slot_reg == 2'd0)) begin
            v0_reg <= vtx_in;
        end
        if (accept && (slot_reg == 2'd1)) begin
            v1_reg <= vtx_in;
        end
    end

    // vertex slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= 2'd0;
        end else if (accept) begin
            slot_reg <= third ? 2'd0 : slot_reg + 2'd1;
        end
    end

endmodule

@@ rtl/core/ttuv_back.sv @@
module ttuv_back #(
    parameter int DATA_WIDTH = ttuv_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = ttuv_pkg::FRAC_BITS_DEF,
    parameter int REC_WIDTH  = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [REC_WIDTH-1:0]          rec,
    input  ttuv_pkg::ttuv_q_stat_t        q_stat,
    output logic                          q_rd,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [8*DATA_WIDTH-1:0]       m_tdata,
    output logic                          m_tlast,
    output logic [0:0]                    m_tuser
);
    import ttuv_pkg::*;

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int VW  = VTX_FIELDS * W;
    localparam int DLW = W + 1;
    localparam int PW  = 2 * W + 2;
    localparam int MW  = 2 * W + 1;
    localparam int NW  = MW + F;

    bk_state_t state_reg, state_next;

    logic [3:0]               step_reg;
    logic [1:0]               comp_reg;
    logic [1:0]               vidx_reg;
    logic signed [PW-1:0]     prod_reg;
    logic signed [PW-1:0]     hold_reg;
    logic signed [PW-1:0]     nd_reg [4];
    logic [W-1:0]             tan_reg [3];
    logic                     degen_reg;
    logic                     m_tvalid_reg;
    logic [8*W-1:0]           m_tdata_reg;
    logic                     m_tlast_reg;
    logic                     m_tuser_reg;

    logic signed [DLW-1:0]    dl [NUM_DELTAS];
    logic [2:0]               mul_j;
    logic [1:0]               mul_c;
    logic [3:0]               cons_j;
    logic signed [DLW-1:0]    op_a;
    logic signed [DLW-1:0]    op_b;
    logic signed [PW-1:0]     prod;
    logic [1:0]               nsel;
    logic signed [PW-1:0]     nd_n;
    logic [PW-1:0]            n_abs;
    logic [PW-1:0]            d_abs;
    logic [NW-1:0]            div_num;
    logic                     div_neg;
    logic                     div_start;
    logic                     out_load;
    logic [W-1:0]             div_res;
    ttuv_div_stat_t           div_stat;

    // unpack deltas
    always_comb begin
        for (int j = 0; j < NUM_DELTAS; j++) begin
            dl[j] = rec[TRI_VERTS*VW + j*DLW +: DLW];
        end
    end

    // product order: du0*dv1, du1*dv0, then dv1*e0 and dv0*e1 per component
    assign mul_j  = step_reg[2:0];
    assign mul_c  = mul_j[2:1] - 2'd1;
    assign cons_j = step_reg - 4'd1;

    always_comb begin
        if (mul_j == 3'd0) begin
            op_a = dl[DL_DU0];
            op_b = dl[DL_DV1];
        end else if (mul_j == 3'd1) begin
            op_a = dl[DL_DU1];
            op_b = dl[DL_DV0];
        end else if (mul_j[0]) begin
            op_a = dl[DL_DV0];
            op_b = dl[DL_E1 + int'(mul_c)];
        end else begin
            op_a = dl[DL_DV1];
            op_b = dl[DL_E0 + int'(mul_c)];
        end
    end

    assign prod = op_a * op_b;

    // divider operands: magnitudes and combined sign
    assign nsel    = comp_reg + 2'd1;
    assign nd_n    = nd_reg[nsel];
    assign n_abs   = nd_n[PW-1] ? (PW'(0) - nd_n) : nd_n;
    assign d_abs   = nd_reg[0][PW-1] ? (PW'(0) - nd_reg[0]) : nd_reg[0];
    assign div_num = {n_abs[MW-1:0], {F{1'b0}}};
    assign div_neg = nd_n[PW-1] ^ nd_reg[0][PW-1];

    ttuv_div #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (d_abs[MW-1:0]),
        .neg     (div_neg),
        .stat    (div_stat),
        .res     (div_res)
    );

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and strobes
    always_comb begin
        state_next = state_reg;
        q_rd       = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                if (!q_stat.empty) begin
                    q_rd       = 1'b1;
                    state_next = BK_MUL;
                end
            end
            BK_MUL: begin
                if (step_reg == 4'd8) begin
                    state_next = (nd_reg[0] == '0) ? BK_OUT : BK_DIV;
                end
            end
            BK_DIV: begin
                if (!div_stat.busy) begin
                    div_start  = 1'b1;
                    state_next = BK_WAIT;
                end
            end
            BK_WAIT: begin
                if (div_stat.done) begin
                    state_next = (comp_reg == 2'd2) ? BK_OUT : BK_DIV;
                end
            end
            BK_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load = 1'b1;
                    if (vidx_reg == 2'd2) begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // counters and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= '0;
            comp_reg     <= '0;
            vidx_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (state_reg == BK_IDLE) begin
                step_reg <= '0;
                vidx_reg <= '0;
            end else if (state_reg == BK_MUL) begin
                step_reg <= step_reg + 4'd1;
                comp_reg <= '0;
            end
            if ((state_reg == BK_WAIT) && div_stat.done) begin
                comp_reg <= comp_reg + 2'd1;
            end
            if (out_load) begin
                vidx_reg <= vidx_reg + 2'd1;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // products, determinant and numerators
    always_ff @(posedge aclk) begin
        if (state_reg == BK_MUL) begin
            prod_reg <= prod;
            if (step_reg != 4'd0) begin
                if (!cons_j[0]) begin
                    hold_reg <= prod_reg;
                end else begin
                    nd_reg[cons_j[2:1]] <= hold_reg - prod_reg;
                end
            end
            if (step_reg == 4'd8) begin
                degen_reg <= (nd_reg[0] == '0);
                for (int c = 0; c < 3; c++) begin
                    tan_reg[c] <= '0;
                end
            end
        end
        if ((state_reg == BK_WAIT) && div_stat.done) begin
            tan_reg[comp_reg] <= div_res;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {tan_reg[2], tan_reg[1], tan_reg[0], rec[vidx_reg*VW +: VW]};
            m_tlast_reg <= (vidx_reg == 2'd2);
            m_tuser_reg <= degen_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tlast    = m_tlast_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

@@ rtl/core/triangle_tangent_from_uv.sv @@
// channel  | dir | tdata (lowest bit up)                                | tlast | tuser
// s_       | in  | pos_x, pos_y, pos_z, tex_u, tex_v, zero pad to bytes |  -    |  -
// m_       | out | out_pos_x..out_tex_v, tangent_x, tangent_y, tangent_z | last  | degenerate
//
// input words are taken every cycle until the third vertex of a triangle finds the
// two-entry triangle queue full. the back end handles one triangle at a time; its pace is
// set by the shared bit-serial divider that runs once per tangent component.
// degenerate or saturating triangles finish sooner.
// aresetn is synchronous; it clears the vertex slot, queue and sequencer.
// a stalled m_ side backs up into the queue, then into s_tready.
module triangle_tangent_from_uv #(
    parameter int DATA_WIDTH = ttuv_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = ttuv_pkg::FRAC_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v
    input  logic [((5*DATA_WIDTH+7)/8)*8-1:0]      s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // out_pos_x, out_pos_y, out_pos_z, out_tex_u, out_tex_v, tangent_x, tangent_y, tangent_z
    output logic [8*DATA_WIDTH-1:0]                m_tdata,
    output logic                                   m_tlast,
    // degenerate
    output logic [0:0]                             m_tuser
);
    import ttuv_pkg::*;

    localparam int W    = DATA_WIDTH;
    localparam int RECW = TRI_VERTS * VTX_FIELDS * W + NUM_DELTAS * (W + 1);

    ttuv_q_stat_t    q_stat;
    logic            q_wr;
    logic            q_rd;
    logic [RECW-1:0] q_wdata;
    logic [RECW-1:0] q_rdata;

    ttuv_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .REC_WIDTH  (RECW)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .vtx_in   (s_tdata[5*W-1:0]),
        .q_stat   (q_stat),
        .q_wr     (q_wr),
        .q_data   (q_wdata)
    );

    ttuv_fifo #(
        .WIDTH (RECW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (q_wr),
        .wr_data (q_wdata),
        .rd_en   (q_rd),
        .rd_data (q_rdata),
        .stat    (q_stat)
    );

    ttuv_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .REC_WIDTH  (RECW)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rec      (q_rdata),
        .q_stat   (q_stat),
        .q_rd     (q_rd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // degenerate words carry a zero tangent
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[8*W-1:5*W] == '0))
        else $error("degenerate word with nonzero tangent");

    // input stalls only when a finished triangle meets a full queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> q_stat.full)
        else $error("input stalled with room in the queue");

    // no triangle pushed into a full queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_wr |-> !q_stat.full)
        else $error("triangle written into full queue");

endmodule

@@ sim/tangent_checker.sv @@
module tangent_checker #(
    parameter int W    = ttuv_pkg::DATA_WIDTH_DEF,
    parameter int FRAC = ttuv_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v
    input  logic [((5*W+7)/8)*8-1:0]      s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // out_pos_x, out_pos_y, out_pos_z, out_tex_u, out_tex_v, tangent_x, tangent_y, tangent_z
    input  logic [8*W-1:0]                m_tdata,
    input  logic                          m_tlast,
    // degenerate
    input  logic [0:0]                    m_tuser,
    output int                            mismatches,
    output int                            outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // one vertex as it sits in the input word, pos_x lowest
    typedef struct packed {
        logic signed [W-1:0] tex_v;
        logic signed [W-1:0] tex_u;
        logic signed [W-1:0] pos_z;
        logic signed [W-1:0] pos_y;
        logic signed [W-1:0] pos_x;
    } vertex_t;

    // one output word with its last and degenerate flags on top
    typedef struct packed {
        logic            last;
        logic            degen;
        logic [W-1:0]    tan_z;
        logic [W-1:0]    tan_y;
        logic [W-1:0]    tan_x;
        vertex_t         vtx;
    } vertex_out_t;

    // wide enough for every product and the shifted numerator
    typedef logic signed [127:0] wide_t;

    vertex_out_t pending_vertices[$];
    vertex_t     held_vertex[2];
    int unsigned vertex_slot;
    vertex_t     in_vertex;
    vertex_out_t got, want;

    function automatic wide_t widen(input logic signed [W-1:0] x);
        widen = x;
    endfunction

    // truncating quotient num * 2^FRAC / det, saturated to W bits
    function automatic logic [W-1:0] tangent_component(input wide_t num, input wide_t det);
        logic [127:0] num_mag, det_mag, quo, lim, r;
        logic         neg;
        neg     = num[127] ^ det[127];
        num_mag = num[127] ? -num : num;
        det_mag = det[127] ? -det : det;
        quo     = (num_mag << FRAC) / det_mag;
        lim     = neg ? (128'd1 << (W-1)) : (128'd1 << (W-1)) - 128'd1;
        if (quo > lim)
            quo = lim;
        r = neg ? -quo : quo;
        return r[W-1:0];
    endfunction

    // shared tangent of a triangle, then its three output words
    function automatic void predict_triangle(input vertex_t a, input vertex_t b,
                                             input vertex_t c);
        wide_t        du0, du1, dv0, dv1, det, e0, e1, num;
        logic [W-1:0] pa[3], pb[3], pc[3], tan[3];
        logic         degen;
        vertex_out_t  r;
        int           k;
        du0 = widen(b.tex_u) - widen(a.tex_u);
        du1 = widen(c.tex_u) - widen(a.tex_u);
        dv0 = widen(b.tex_v) - widen(a.tex_v);
        dv1 = widen(c.tex_v) - widen(a.tex_v);
        det = du0 * dv1 - du1 * dv0;
        degen = (det == 0);
        pa = '{a.pos_x, a.pos_y, a.pos_z};
        pb = '{b.pos_x, b.pos_y, b.pos_z};
        pc = '{c.pos_x, c.pos_y, c.pos_z};
        for (k = 0; k < 3; k++) begin
            e0 = widen(pb[k]) - widen(pa[k]);
            e1 = widen(pc[k]) - widen(pa[k]);
            num = dv1 * e0 - dv0 * e1;
            tan[k] = degen ? '0 : tangent_component(num, det);
        end
        r.degen = degen;
        r.tan_x = tan[0];
        r.tan_y = tan[1];
        r.tan_z = tan[2];
        r.last  = 1'b0;
        r.vtx   = a;
        pending_vertices = {pending_vertices, r};
        r.vtx   = b;
        pending_vertices = {pending_vertices, r};
        r.last  = 1'b1;
        r.vtx   = c;
        pending_vertices = {pending_vertices, r};
    endfunction

    task automatic check_field(input string name, input logic [W-1:0] exp_v,
                               input logic [W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // sample both channels at the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            vertex_slot = 0;
            pending_vertices.delete();
        end else begin
            // output word against the oldest expected one
            if (m_tvalid && m_tready) begin
                got = {m_tlast, m_tuser[0], m_tdata};
                if (pending_vertices.size() == 0) begin
                    $display("%0t ns: unexpected output word, expected none, got %h",
                             $time, got);
                    mismatches++;
                end else begin
                    want = pending_vertices.pop_front();
                    check_field("out_pos_x", want.vtx.pos_x, got.vtx.pos_x);
                    check_field("out_pos_y", want.vtx.pos_y, got.vtx.pos_y);
                    check_field("out_pos_z", want.vtx.pos_z, got.vtx.pos_z);
                    check_field("out_tex_u", want.vtx.tex_u, got.vtx.tex_u);
                    check_field("out_tex_v", want.vtx.tex_v, got.vtx.tex_v);
                    check_field("tangent_x", want.tan_x, got.tan_x);
                    check_field("tangent_y", want.tan_y, got.tan_y);
                    check_field("tangent_z", want.tan_z, got.tan_z);
                    check_field("degenerate", W'(want.degen), W'(got.degen));
                    check_field("last", W'(want.last), W'(got.last));
                end
            end
            // input word: hold the first two vertices, the third closes the triangle
            if (s_tvalid && s_tready) begin
                in_vertex = s_tdata[5*W-1:0];
                if (vertex_slot < 2) begin
                    held_vertex[vertex_slot] = in_vertex;
                    vertex_slot++;
                end else begin
                    predict_triangle(held_vertex[0], held_vertex[1], in_vertex);
                    vertex_slot = 0;
                end
            end
        end
        outstanding = pending_vertices.size();
    end

endmodule

@@ sim/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W  = ttuv_pkg::DATA_WIDTH_DEF;
    localparam int SW = ((5*W+7)/8)*8;

    localparam logic [W-1:0] ONE  = 32'h0001_0000;
    localparam logic [W-1:0] MAXV = 32'h7FFF_FFFF;
    localparam logic [W-1:0] MINV = 32'h8000_0000;
    localparam logic [W-1:0] ALL1 = 32'hFFFF_FFFF;

    localparam int TRIANGLES = 135;

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [SW-1:0] s_tdata;
    logic          m_tvalid;
    logic          m_tready;
    logic [8*W-1:0] m_tdata;
    logic          m_tlast;
    logic [0:0]    m_tuser;

    int mismatches;
    int outstanding;
    int stall_requests;
    int stall_served;
    int hold_left;
    logic idle_on;

    triangle_tangent_from_uv dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    tangent_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 4 ns clock
    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // overall time limit
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // output side: random idle cycles, plus a long hold-off on request
    initial begin
        m_tready = 1'b0;
        stall_served = 0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_requests != stall_served) begin
                stall_served++;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !(idle_on && $urandom_range(99) < 7);
            end
        end
    end

    function automatic logic [SW-1:0] vtx(input logic [W-1:0] x, y, z, u, v);
        logic [SW-1:0] r;
        r = '0;
        r[5*W-1:0] = {v, u, z, y, x};
        return r;
    endfunction

    // field value: full range, extremes, or a typical small mesh value
    function automatic logic [W-1:0] rnd_val(input int kind);
        logic [W-1:0] r;
        case (kind)
            0, 1: begin
                r = $urandom;
            end
            2: begin
                case ($urandom_range(4))
                    0: r = MAXV;
                    1: r = MINV;
                    2: r = '0;
                    3: r = ALL1;
                    default: r = ONE;
                endcase
            end
            default: begin
                r = $urandom_range(32'h001F_FFFF) - 32'h0010_0000;
            end
        endcase
        return r;
    endfunction

    // present one word, with an occasional gap before it
    task automatic send_vertex(input logic [SW-1:0] word);
        int gap;
        gap = (idle_on && $urandom_range(99) < 7) ? $urandom_range(1, 4) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_random_triangle();
        logic [W-1:0] f[3][5];
        int pos_kind, tex_kind, shape, k, j;
        pos_kind = $urandom_range(9);
        tex_kind = $urandom_range(9);
        for (k = 0; k < 3; k++)
            for (j = 0; j < 5; j++)
                f[k][j] = rnd_val(j < 3 ? pos_kind : tex_kind);
        shape = $urandom_range(9);
        // repeated uv on the last two vertices, or on all three, gives a zero determinant
        if (shape == 0) begin
            f[2][3] = f[1][3];
            f[2][4] = f[1][4];
        end else if (shape == 1) begin
            for (k = 1; k < 3; k++) begin
                f[k][3] = f[0][3];
                f[k][4] = f[0][4];
            end
        end
        for (k = 0; k < 3; k++)
            send_vertex(vtx(f[k][0], f[k][1], f[k][2], f[k][3], f[k][4]));
    endtask

    initial begin
        int t;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        stall_requests = 0;
        idle_on = 1'b1;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        // unit tangent along x
        send_vertex(vtx(0, 0, 0, 0, 0));
        send_vertex(vtx(ONE, 0, 0, ONE, 0));
        send_vertex(vtx(0, ONE, 0, 0, ONE));
        // zero determinant, all uv equal
        send_vertex(vtx(ONE, 2*ONE, 3*ONE, 5*ONE, 7*ONE));
        send_vertex(vtx(4*ONE, ONE, MINV, 5*ONE, 7*ONE));
        send_vertex(vtx(MAXV, 0, ONE, 5*ONE, 7*ONE));
        // zero determinant, collinear uv
        send_vertex(vtx(0, 0, 0, 0, 0));
        send_vertex(vtx(ONE, ONE, 0, ONE, ONE));
        send_vertex(vtx(0, 3*ONE, ONE, 2*ONE, 2*ONE));
        // tiny determinant: saturate high on x, low on y
        send_vertex(vtx(0, 0, 0, 0, 0));
        send_vertex(vtx(MAXV, MINV, 0, 1, 0));
        send_vertex(vtx(0, 0, ONE, 0, 1));
        // extreme uv deltas in both directions
        send_vertex(vtx(MINV, MINV, MINV, MINV, MINV));
        send_vertex(vtx(MAXV, MAXV, MAXV, MAXV, MINV));
        send_vertex(vtx(MINV, MAXV, 0, MINV, MAXV));
        // all-ones and alternating bit patterns
        send_vertex(vtx(ALL1, ALL1, ALL1, ALL1, ALL1));
        send_vertex(vtx(0, 0, 0, 0, ALL1));
        send_vertex(vtx(32'h5555_5555, 32'hAAAA_AAAA, 1, ALL1, 0));
        // negative unit tangent
        send_vertex(vtx(0, 0, 0, 0, 0));
        send_vertex(vtx(ONE, 0, 0, -ONE, 0));
        send_vertex(vtx(0, ONE, 0, 0, ONE));
        // fractional values, inexact quotient
        send_vertex(vtx(32'h0000_3000, 32'hFFFF_7000, 32'h0002_8000, 32'h0000_8000, 32'h0000_3000));
        send_vertex(vtx(32'h0001_1234, 32'h0000_0567, 32'hFFFE_0001, 32'h0003_0000, 32'h0000_8001));
        send_vertex(vtx(32'hFFFF_0F0F, 32'h0002_0000, 32'h0000_0003, 32'h0000_5555, 32'h0001_AAAA));

        // random triangles
        for (t = 0; t < TRIANGLES; t++) begin
            if (t == 40)
                stall_requests++;
            if (t == 70) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                while (outstanding != 0) @(negedge aclk);
            end
            if (t == 90)
                idle_on = 1'b0;
            if (t == 120)
                idle_on = 1'b1;
            send_random_triangle();
        end

        // drain and finish
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (150) @(negedge aclk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ triangle_tangent_from_uv.f @@
rtl/core/ttuv_pkg.sv
rtl/core/ttuv_fifo.sv
rtl/core/ttuv_div.sv
rtl/core/ttuv_front.sv
rtl/core/ttuv_back.sv
rtl/core/triangle_tangent_from_uv.sv
sim/tangent_checker.sv
sim/testbench.sv
